### rtl/swf_pkg.sv
// Package: types, constants and saturation helpers for the shallow-water flux step core.
`timescale 1ns / 1ps
`default_nettype none
package swf_pkg;

   localparam int MAX_CELLS = 128;
   localparam int VW        = 32;
   localparam int AW        = $clog2(MAX_CELLS);
   localparam int CNT_W     = $clog2(MAX_CELLS + 1);
   localparam int PW        = 2 * (VW + 2);
   localparam int QQ_W      = 2 * VW - 1;
   localparam int DIV_CNT_W = $clog2(QQ_W + 1);
   localparam int FRAC      = 16;

   localparam int SR_W   = 17;
   localparam int GRAV_W = 22;
   localparam int DIFF_W = 17;
   localparam int CELL_W = 8;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 22;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_SAT = 2'd1;
   localparam logic [1:0] STAT_DRY = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_STEP_RATIO = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GRAVITY    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_DIFFUSION  = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_CELLS      = 2'd3;

   localparam logic [SR_W-1:0]   STEP_RATIO_RST = 17'd655;
   localparam logic [GRAV_W-1:0] GRAVITY_RST    = 22'd642908;
   localparam logic [DIFF_W-1:0] DIFFUSION_RST  = 17'd32768;
   localparam logic [CELL_W-1:0] CELLS_RST      = 8'd100;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [6:0]           cell_index;
      logic signed [31:0]   depth_in;
      logic signed [31:0]   discharge_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0]   depth_out;
      logic signed [31:0]   discharge_out;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic signed [VW-1:0] h;
      logic signed [VW-1:0] q;
      logic signed [VW-1:0] e;
      logic signed [VW-1:0] f1;
      logic signed [VW-1:0] f2;
   } win_type;

   typedef struct packed {
      logic hq;
      logic e;
      logic f1;
      logic f2;
   } win_ld_type;

   function automatic logic sat_hit(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = {{(PW-VW+1){1'b0}}, {(VW-1){1'b1}}};
      lo = ~hi;
      return (v > hi) || (v < lo);
   endfunction

   function automatic logic signed [VW-1:0] sat_val(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = {{(PW-VW+1){1'b0}}, {(VW-1){1'b1}}};
      lo = ~hi;
      if (v > hi) return hi[VW-1:0];
      if (v < lo) return lo[VW-1:0];
      return v[VW-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/shallow_water_flux_step_core.sv
// Top level: 1-D shallow-water grid store with a Rusanov flux time step.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to 128 cells of depth and discharge (signed Q16.16). A write
// goes straight into the grid memories; a read registers the cell, then the
// result register. A step walks the active cells once through a two-cell
// window chain; each cell's convective term Q*Q/H comes from the bit-serial
// divider, and the two boundary cells are written as copies during the step.
// One operation is in flight at a time. The grid needs no clearing after
// reset: cells are valid once written.
module shallow_water_flux_step_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  swf_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output swf_pkg::rsp_type             rsp_data,
   input  wire                          csr_we,
   input  wire [swf_pkg::CSR_AW-1:0]    csr_index,
   input  wire [swf_pkg::CSR_DW-1:0]    csr_wdata
);
   import swf_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RDOP  = 5'd1;
   localparam logic [4:0] S_RDOUT = 5'd2;
   localparam logic [4:0] S_FETCH = 5'd3;
   localparam logic [4:0] S_LOAD  = 5'd4;
   localparam logic [4:0] S_MQQ   = 5'd5;
   localparam logic [4:0] S_MHH   = 5'd6;
   localparam logic [4:0] S_MG    = 5'd7;
   localparam logic [4:0] S_MG2   = 5'd8;
   localparam logic [4:0] S_GH    = 5'd9;
   localparam logic [4:0] S_DIV   = 5'd10;
   localparam logic [4:0] S_E     = 5'd11;
   localparam logic [4:0] S_F1M   = 5'd12;
   localparam logic [4:0] S_F1    = 5'd13;
   localparam logic [4:0] S_F2M   = 5'd14;
   localparam logic [4:0] S_F2    = 5'd15;
   localparam logic [4:0] S_U1M   = 5'd16;
   localparam logic [4:0] S_U1    = 5'd17;
   localparam logic [4:0] S_U2M   = 5'd18;
   localparam logic [4:0] S_U2    = 5'd19;
   localparam logic [4:0] S_WR    = 5'd20;
   localparam logic [4:0] S_WR0   = 5'd21;
   localparam logic [4:0] S_WRN   = 5'd22;
   localparam logic [4:0] S_SHIFT = 5'd23;
   localparam logic [4:0] S_DONE  = 5'd24;
   localparam logic [4:0] S_OUT   = 5'd25;

   logic [4:0]        state_ff, state_in;
   logic [SR_W-1:0]   step_ratio_ff;
   logic [GRAV_W-1:0] gravity_ff;
   logic [DIFF_W-1:0] diffusion_ff;
   logic [CELL_W-1:0] cells_ff;

   logic signed [VW-1:0] depth_mem [MAX_CELLS];
   logic signed [VW-1:0] dis_mem   [MAX_CELLS];
   logic signed [VW-1:0] rd_h_ff, rd_q_ff;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic signed [VW-1:0] mem_wh, mem_wq;

   logic [CNT_W-1:0]     idx_ff, idx_in, n_ff, n_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [VW+1:0] mul_a, mul_b;
   logic signed [PW-1:0] shr;
   logic signed [VW-1:0] hh_ff, gh_ff, conv_ff, newh_ff, newq_ff;
   logic                 sat_ff, dry_ff, sat_in, dry_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic                 req_xfer, rsp_load;

   win_type              c0_val, c0_q, c1_q;
   win_ld_type           c0_ld, c1_ld;

   logic                 div_start, div_busy, h_dry;
   logic [QQ_W-1:0]      quot;

   logic signed [VW:0]   d_h, d_q, d_f1, d_f2, hs_q, hs_e;
   logic signed [PW-1:0] f1_raw, f2_raw, u1_raw, u2_raw, e_raw, conv_ext;
   logic                 conv_sat;
   logic signed [VW-1:0] conv_val;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff <= STEP_RATIO_RST;
         gravity_ff    <= GRAVITY_RST;
         diffusion_ff  <= DIFFUSION_RST;
         cells_ff      <= CELLS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_RATIO: step_ratio_ff <= csr_wdata[SR_W-1:0];
            CSR_GRAVITY:    gravity_ff    <= csr_wdata[GRAV_W-1:0];
            CSR_DIFFUSION:  diffusion_ff  <= csr_wdata[DIFF_W-1:0];
            CSR_CELLS:      cells_ff      <= csr_wdata[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // grid memories
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wh    = newh_ff;
      mem_wq    = newq_ff;
      if (req_xfer && req_data.opcode == OP_WRITE) begin
         mem_we    = 1'b1;
         mem_waddr = req_data.cell_index;
         mem_wh    = req_data.depth_in;
         mem_wq    = req_data.discharge_in;
      end else if (state_ff == S_WR) begin
         mem_we    = 1'b1;
         mem_waddr = idx_ff[AW-1:0] - 1'b1;
      end else if (state_ff == S_WR0) begin
         mem_we    = 1'b1;
         mem_waddr = '0;
      end else if (state_ff == S_WRN) begin
         mem_we    = 1'b1;
         mem_waddr = idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_waddr] <= mem_wh;
         dis_mem[mem_waddr]   <= mem_wq;
      end
      rd_h_ff <= depth_mem[addr_ff];
      rd_q_ff <= dis_mem[addr_ff];
   end

   // shared multiplier
   assign d_h  = {c0_q.h[VW-1], c0_q.h} - {c1_q.h[VW-1], c1_q.h};
   assign d_q  = {c0_q.q[VW-1], c0_q.q} - {c1_q.q[VW-1], c1_q.q};
   assign d_f1 = {c0_q.f1[VW-1], c0_q.f1} - {c1_q.f1[VW-1], c1_q.f1};
   assign d_f2 = {c0_q.f2[VW-1], c0_q.f2} - {c1_q.f2[VW-1], c1_q.f2};
   assign hs_q = $signed({c0_q.q[VW-1], c0_q.q} + {c1_q.q[VW-1], c1_q.q}) >>> 1;
   assign hs_e = $signed({c0_q.e[VW-1], c0_q.e} + {c1_q.e[VW-1], c1_q.e}) >>> 1;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MQQ: begin
            mul_a = {{2{c0_q.q[VW-1]}}, c0_q.q};
            mul_b = {{2{c0_q.q[VW-1]}}, c0_q.q};
         end
         S_MHH: begin
            mul_a = {{2{c0_q.h[VW-1]}}, c0_q.h};
            mul_b = {{2{c0_q.h[VW-1]}}, c0_q.h};
         end
         S_MG2: begin
            mul_a = {{(VW+2-GRAV_W){1'b0}}, gravity_ff};
            mul_b = {{2{hh_ff[VW-1]}}, hh_ff};
         end
         S_F1M: begin
            mul_a = {{(VW+2-DIFF_W){1'b0}}, diffusion_ff};
            mul_b = {d_h[VW], d_h};
         end
         S_F2M: begin
            mul_a = {{(VW+2-DIFF_W){1'b0}}, diffusion_ff};
            mul_b = {d_q[VW], d_q};
         end
         S_U1M: begin
            mul_a = {{(VW+2-SR_W){1'b0}}, step_ratio_ff};
            mul_b = {d_f1[VW], d_f1};
         end
         S_U2M: begin
            mul_a = {{(VW+2-SR_W){1'b0}}, step_ratio_ff};
            mul_b = {d_f2[VW], d_f2};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign shr = prod_ff >>> FRAC;

   // divider for Q*Q/H
   assign h_dry     = c0_q.h[VW-1] || (c0_q.h == '0);
   assign div_start = (state_ff == S_MHH) && !h_dry;

   swf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[QQ_W-1:0]),
      .divisor  (c0_q.h[VW-2:0]),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign conv_sat = |quot[QQ_W-1:VW-1];
   assign conv_val = conv_sat ? {1'b0, {(VW-1){1'b1}}} : {1'b0, quot[VW-2:0]};

   assign conv_ext = {{(PW-VW){conv_ff[VW-1]}}, conv_ff};
   assign e_raw    = conv_ext + ({{(PW-VW){gh_ff[VW-1]}}, gh_ff} >>> 1);
   assign f1_raw   = {{(PW-VW-1){hs_q[VW]}}, hs_q} - shr;
   assign f2_raw   = {{(PW-VW-1){hs_e[VW]}}, hs_e} - shr;
   assign u1_raw   = {{(PW-VW){c1_q.h[VW-1]}}, c1_q.h} - shr;
   assign u2_raw   = {{(PW-VW){c1_q.q[VW-1]}}, c1_q.q} - shr;

   // window chain: cell 0 is the cell being worked on, cell 1 its left neighbour
   always_comb begin
      c0_val.h  = rd_h_ff;
      c0_val.q  = rd_q_ff;
      c0_val.e  = sat_val(e_raw);
      c0_val.f1 = sat_val(f1_raw);
      c0_val.f2 = sat_val(f2_raw);
      c0_ld.hq  = (state_ff == S_LOAD);
      c0_ld.e   = (state_ff == S_E);
      c0_ld.f1  = (state_ff == S_F1);
      c0_ld.f2  = (state_ff == S_F2);
      c1_ld.hq  = (state_ff == S_SHIFT);
      c1_ld.e   = (state_ff == S_SHIFT);
      c1_ld.f1  = (state_ff == S_SHIFT);
      c1_ld.f2  = (state_ff == S_SHIFT);
   end

   swf_cell u_cell0 (
      .clock (clock),
      .ld    (c0_ld),
      .d_in  (c0_val),
      .d_out (c0_q)
   );

   swf_cell u_cell1 (
      .clock (clock),
      .ld    (c1_ld),
      .d_in  (c0_q),
      .d_out (c1_q)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_MG) hh_ff <= sat_val(shr);
      if (state_ff == S_GH) gh_ff <= sat_val(shr);
      if (state_ff == S_DIV && !div_busy) conv_ff <= h_dry ? '0 : conv_val;
      if (state_ff == S_U1) newh_ff <= sat_val(u1_raw);
      if (state_ff == S_U2) newq_ff <= sat_val(u2_raw);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      sat_in   = sat_ff;
      dry_in   = dry_ff;
      res_in   = res_ff;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_in  = '0;
               addr_in = req_data.cell_index;
               case (req_data.opcode)
                  OP_READ: state_in = S_RDOP;
                  OP_STEP: begin
                     sat_in  = 1'b0;
                     dry_in  = 1'b0;
                     idx_in  = '0;
                     addr_in = '0;
                     if (cells_ff < CELL_W'(3)) n_in = CNT_W'(3);
                     else if (cells_ff > CELL_W'(MAX_CELLS)) n_in = CNT_W'(MAX_CELLS);
                     else n_in = CNT_W'(cells_ff);
                     state_in = S_FETCH;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_RDOP:  state_in = S_RDOUT;
         S_RDOUT: begin
            res_in.depth_out     = rd_h_ff;
            res_in.discharge_out = rd_q_ff;
            state_in = S_OUT;
         end
         S_FETCH: state_in = S_LOAD;
         S_LOAD:  state_in = S_MQQ;
         S_MQQ:   state_in = S_MHH;
         S_MHH: begin
            if (h_dry) dry_in = 1'b1;
            state_in = S_MG;
         end
         S_MG: begin
            if (sat_hit(shr)) sat_in = 1'b1;
            state_in = S_MG2;
         end
         S_MG2: state_in = S_GH;
         S_GH: begin
            if (sat_hit(shr)) sat_in = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_busy) begin
               if (!h_dry && conv_sat) sat_in = 1'b1;
               state_in = S_E;
            end
         end
         S_E: begin
            if (sat_hit(e_raw)) sat_in = 1'b1;
            state_in = (idx_ff == '0) ? S_SHIFT : S_F1M;
         end
         S_F1M: state_in = S_F1;
         S_F1: begin
            if (sat_hit(f1_raw)) sat_in = 1'b1;
            state_in = S_F2M;
         end
         S_F2M: state_in = S_F2;
         S_F2: begin
            if (sat_hit(f2_raw)) sat_in = 1'b1;
            state_in = (idx_ff >= CNT_W'(2)) ? S_U1M : S_SHIFT;
         end
         S_U1M: state_in = S_U1;
         S_U1: begin
            if (sat_hit(u1_raw)) sat_in = 1'b1;
            state_in = S_U2M;
         end
         S_U2M: state_in = S_U2;
         S_U2: begin
            if (sat_hit(u2_raw)) sat_in = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            if (idx_ff == CNT_W'(2)) state_in = S_WR0;
            else if (idx_ff == n_ff - 1'b1) state_in = S_WRN;
            else state_in = S_SHIFT;
         end
         S_WR0: state_in = (idx_ff == n_ff - 1'b1) ? S_WRN : S_SHIFT;
         S_WRN: state_in = S_SHIFT;
         S_SHIFT: begin
            idx_in  = idx_ff + 1'b1;
            addr_in = idx_in[AW-1:0];
            state_in = (idx_in == n_ff) ? S_DONE : S_FETCH;
         end
         S_DONE: begin
            res_in.status = sat_ff ? STAT_SAT : (dry_ff ? STAT_DRY : STAT_OK);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
         dry_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         sat_ff   <= sat_in;
         dry_ff   <= dry_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      res_ff  <= res_in;
      if (rsp_load) rsp_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### rtl/swf_cell.sv
// Window cell: holds depth, discharge, momentum flux and interface fluxes of one grid cell.
`timescale 1ns / 1ps
`default_nettype none
module swf_cell (
   input  wire               clock,
   input  swf_pkg::win_ld_type ld,
   input  swf_pkg::win_type  d_in,
   output swf_pkg::win_type  d_out
);
   import swf_pkg::*;

   win_type cell_ff;

   always_ff @(posedge clock) begin
      if (ld.hq) begin
         cell_ff.h <= d_in.h;
         cell_ff.q <= d_in.q;
      end
      if (ld.e) cell_ff.e <= d_in.e;
      if (ld.f1) cell_ff.f1 <= d_in.f1;
      if (ld.f2) cell_ff.f2 <= d_in.f2;
   end

   assign d_out = cell_ff;

endmodule
`default_nettype wire

### rtl/swf_div.sv
// Restoring divider, one quotient bit per cycle, for the convective term Q*Q/H.
`timescale 1ns / 1ps
`default_nettype none
module swf_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [swf_pkg::QQ_W-1:0]     dividend,
   input  wire [swf_pkg::VW-2:0]       divisor,
   output logic                        busy,
   output logic [swf_pkg::QQ_W-1:0]    quotient
);
   import swf_pkg::*;

   logic [VW-1:0]        rem_ff;
   logic [QQ_W-1:0]      quo_ff;
   logic [VW-2:0]        dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic [VW-1:0]        trial;
   logic                 take;

   assign trial = {rem_ff[VW-2:0], quo_ff[QQ_W-1]};
   assign take  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(QQ_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? (trial - {1'b0, dvs_ff}) : trial;
         quo_ff <= {quo_ff[QQ_W-2:0], take};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
